/* design/lgs_pkg.sv */
// Shared types, constants and the B3/S23 next-state function for the life stencil.
package lgs_pkg;

    localparam int MAX_SIDE_DEFAULT = 1024;
    localparam int BOARD_SIZE_W     = 11;
    localparam int RESET_BOARD_SIZE = 64;
    localparam int WINDOW_W         = 9;
    localparam int CENTER_BIT       = 4;
    localparam int RESULT_FIFO_DEPTH = 4;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic next_alive;
        logic frame_last;
    } result_t;

    // Up to two results enter the result queue per cycle, first then second.
    typedef struct packed {
        logic    push_first;
        result_t first;
        logic    push_second;
        result_t second;
    } result_push_t;

    // Line buffer entry: bit 1 is the row two above, bit 0 the row above.
    typedef logic [1:0] line_entry_t;

    function automatic logic next_state(input logic [WINDOW_W-1:0] w);
        logic [3:0] k;
        logic       res;
        k = '0;
        for (int i = 0; i < WINDOW_W; i++)
        begin
            if (i != CENTER_BIT)
            begin
                k = k + 4'(w[i]);
            end
        end
        case (k)
            4'd3:    res = 1'b1;
            4'd2:    res = w[CENTER_BIT];
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

/* design/lgs_if.sv */
// Valid/ready channel interfaces for cells in, results out and the size register.
interface lgs_in_if;
    logic valid;
    logic ready;
    logic op;
    logic cell_alive;

    modport source (output valid, output op, output cell_alive, input ready);
    modport sink   (input valid, input op, input cell_alive, output ready);
endinterface

interface lgs_out_if;
    logic valid;
    logic ready;
    logic next_alive;
    logic frame_last;

    modport source (output valid, output next_alive, output frame_last, input ready);
    modport sink   (input valid, input next_alive, input frame_last, output ready);
endinterface

interface lgs_cfg_if;
    import lgs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [BOARD_SIZE_W-1:0] board_size;

    modport source (output valid, output board_size, input ready);
    modport sink   (input valid, input board_size, output ready);
endinterface

/* design/life_generation_stencil.sv */
// Top level of the Game of Life (B3/S23) generation stencil over a raster cell stream.
//
//  Channel      Dir  Payload                      Word accepted when
//  cell_in      in   op, cell_alive               cell_in.valid & cell_in.ready
//  result_out   out  next_alive, frame_last       result_out.valid & result_out.ready
//  cfg          in   board_size (11 bits)         cfg.valid & cfg.ready (ready always high)
//
// One input word is taken every cycle while input ready is high. A word is
// accepted and the line buffer memory is read at its column; once the queue
// has room for two results the window shifts, the memory entry is written
// back and zero, one or two results enter a four-word result queue, which
// presents them on the output in order. Input ready drops only while the word
// in the update stage cannot place two results in the queue. Reset clears the
// position counters and restores a board size of 64; the line buffers need
// no clearing since row 0 of every frame writes each column before it is read.
module life_generation_stencil #(
    parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    lgs_in_if.sink      cell_in,
    lgs_out_if.source   result_out,
    lgs_cfg_if.sink     cfg
);
    import lgs_pkg::*;

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int COL_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CMP_W      = (SIDE_W > BOARD_SIZE_W) ? SIDE_W : BOARD_SIZE_W;
    localparam int RESET_SIDE = (RESET_BOARD_SIZE > MAX_SIDE) ? MAX_SIDE : RESET_BOARD_SIZE;

    // Board size and the position of the next word.
    logic [SIDE_W-1:0] board_reg;
    logic [SIDE_W-1:0] board_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [SIDE_W-1:0] row_reg;
    logic [SIDE_W-1:0] row_next;

    // Update stage: the word whose memory read is in flight.
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_cur_reg;
    logic              s1_r_ge1_reg;
    logic              s1_r_ge2_reg;
    logic              s1_r_last_reg;
    logic              s1_c_zero_reg;
    logic              s1_c_last_reg;

    logic [WINDOW_W-1:0] window_reg;
    logic [WINDOW_W-1:0] window_next;

    logic              accept;
    logic              advance;
    logic              room;
    logic              c_last;
    logic              cur;
    logic [CMP_W-1:0]  cfg_size_w;
    line_entry_t       rd_data;
    line_entry_t       wr_data;
    logic              top;
    logic              mid;
    result_push_t      push;

    assign advance       = s1_valid_reg && room;
    assign cell_in.ready = !s1_valid_reg || room;
    assign accept        = cell_in.valid && cell_in.ready;
    assign cfg.ready     = 1'b1;

    assign c_last = (SIDE_W'(col_reg) == board_reg - SIDE_W'(1));
    // A flush word, or any word in the flush row, is a dead cell.
    assign cur    = (cell_in.op == OP_CELL) && (row_reg < board_reg) && cell_in.cell_alive;

    // A written size of zero becomes one; a size above the buffers is clipped.
    always_comb
    begin
        cfg_size_w = CMP_W'(cfg.board_size);
        if (cfg_size_w == '0)
        begin
            board_next = SIDE_W'(1);
        end
        else if (cfg_size_w > CMP_W'(MAX_SIDE))
        begin
            board_next = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            board_next = SIDE_W'(cfg_size_w);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.valid)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (c_last)
            begin
                col_next = '0;
                row_next = (row_reg == board_reg) ? '0 : row_reg + SIDE_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg    <= SIDE_W'(RESET_SIDE);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                board_reg <= board_next;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                window_reg <= window_next;
            end
        end
    end

    // Position flags are worked out on acceptance so the update stage only shifts and counts.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= col_reg;
            s1_cur_reg    <= cur;
            s1_r_ge1_reg  <= (row_reg != '0);
            s1_r_ge2_reg  <= (row_reg > SIDE_W'(1));
            s1_r_last_reg <= (row_reg == board_reg);
            s1_c_zero_reg <= (col_reg == '0);
            s1_c_last_reg <= c_last;
        end
    end

    lgs_line_mem #(
        .DEPTH  (MAX_SIDE),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    // Rows above the board are dead whatever the buffers still hold.
    assign top     = s1_r_ge2_reg && rd_data[1];
    assign mid     = s1_r_ge1_reg && rd_data[0];
    assign wr_data = {rd_data[0], s1_cur_reg};

    // The newest column enters at the low bits; a new row starts from an empty window.
    always_comb
    begin
        window_next = s1_c_zero_reg ? '0 : (window_reg << 3);
        window_next = window_next | WINDOW_W'({s1_cur_reg, mid, top});
    end

    // The first result is the cell one column back; at the row end the last
    // cell follows with a dead column beyond the edge shifted in.
    always_comb
    begin
        push.push_first         = advance && s1_r_ge1_reg && !s1_c_zero_reg;
        push.first.next_alive   = next_state(window_next);
        push.first.frame_last   = 1'b0;
        push.push_second        = advance && s1_r_ge1_reg && s1_c_last_reg;
        push.second.next_alive  = next_state(window_next << 3);
        push.second.frame_last  = s1_r_last_reg;
    end

    lgs_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .result_out (result_out)
    );

endmodule

/* design/lgs_line_mem.sv */
// Two-row line buffer memory with registered read and write-to-read forwarding.
module lgs_line_mem #(
    parameter int DEPTH  = lgs_pkg::MAX_SIDE_DEFAULT,
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output lgs_pkg::line_entry_t rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  lgs_pkg::line_entry_t wr_data
);
    import lgs_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t rd_data_reg;

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/lgs_result_fifo.sv */
// Small result queue that takes up to two results a cycle and delivers one.
module lgs_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lgs_pkg::result_push_t push,
    output logic                  room,
    lgs_out_if.source             result_out
);
    import lgs_pkg::*;

    localparam int PTR_W = $clog2(RESULT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RESULT_FIFO_DEPTH + 1);

    result_t            entry_reg [RESULT_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   second_ptr;
    logic               pop;

    assign pop        = result_out.valid && result_out.ready;
    assign second_ptr = push.push_first ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    // Room means two more results fit, whatever leaves this cycle.
    assign room       = (count_reg <= CNT_W'(RESULT_FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.push_first) + PTR_W'(push.push_second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.push_first) + CNT_W'(push.push_second)
                      - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_first)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.push_second)
        begin
            entry_reg[second_ptr] <= push.second;
        end
    end

    assign result_out.valid      = (count_reg != '0);
    assign result_out.next_alive = entry_reg[rd_ptr_reg].next_alive;
    assign result_out.frame_last = entry_reg[rd_ptr_reg].frame_last;

endmodule

/* design/lgs_checker.sv */
// Port-level checks for the life stencil, bound to its top level.
module lgs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_next_alive,
    input logic out_frame_last
);
    localparam int CNT_W = 40;

    logic [CNT_W-1:0] items_reg;
    logic [CNT_W-1:0] results_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg   <= '0;
            results_reg <= '0;
        end
        else
        begin
            items_reg   <= items_reg + CNT_W'(in_valid && in_ready);
            results_reg <= results_reg + CNT_W'(out_valid && out_ready);
        end
    end

    // A result is never delivered before enough cells have come in to produce it.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> (results_reg < items_reg))
        else $error("result delivered ahead of accepted words");

    // Input is held off only while results are waiting to be taken.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_next_alive) && $stable(out_frame_last)))
        else $error("result changed while stalled");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cell_in.valid),
    .in_ready       (cell_in.ready),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_next_alive (result_out.next_alive),
    .out_frame_last (result_out.frame_last)
);

/* verif/tb_life_generation_stencil.sv */
// Self-checking testbench for the streaming Game of Life generation stencil.
`timescale 1ns / 1ps

module tb_life_generation_stencil;

    import lgs_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_SIDE       = MAX_SIDE_DEFAULT;
    localparam int MAX_WAIT       = 12;
    // The last word can still sit in the update stage, writing its line buffer
    // entry, after every owed result has come, so the bench lets this many
    // cycles pass before a size write.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BULK_WORDS     = 200;
    localparam int PRINT_CAP      = 40;
    localparam int FULL_FRAME     = 32'h7fff_ffff;

    // Neighbor mask of the 3x3 window: every bit but the center one.
    localparam logic [WINDOW_W-1:0] NEIGHBOR_MASK = 9'h1EF;

    // Shorthand results for the rows of the directed table.
    localparam result_t R_NONE       = '{1'b0, 1'b0};
    localparam result_t R_DEAD       = '{1'b0, 1'b0};
    localparam result_t R_ALIVE      = '{1'b1, 1'b0};
    localparam result_t R_DEAD_LAST  = '{1'b0, 1'b1};

    typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;

    // One row of directed stimulus. A row with typed set carries the results
    // that its word must cause; every other word row is checked against the
    // generation predictor below.
    typedef struct packed {
        row_kind_t               kind;
        logic                    op;
        logic                    alive;
        logic [BOARD_SIZE_W-1:0] size;
        logic                    typed;
        logic [1:0]              typed_n;
        result_t                 res_a;
        result_t                 res_b;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 30;

    stim_row_t directed_tbl [DIRECTED_ROWS] = '{
        // A write of zero must land on a one-cell board. A lone live cell has
        // no neighbors and dies; its result is the last of the frame.
        '{ROW_SIZE, OP_CELL,  1'b0, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b1, 11'd0, 1'b1, 2'd1, R_DEAD_LAST, R_NONE},
        // The counters wrapped to row 0. A live cell word sent in the flush
        // row must be taken as a dead cell beyond the edge.
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd1, R_DEAD_LAST, R_NONE},
        // Vertical blinker on a 3x3 board turns into a horizontal one. The
        // flush word at the start of row 1 sits inside the frame and counts
        // as a dead cell.
        '{ROW_SIZE, OP_CELL,  1'b0, 11'd3, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b0, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b0, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b1, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd1, R_DEAD, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b0, 11'd0, 1'b1, 2'd2, R_DEAD, R_DEAD},
        '{ROW_WORD, OP_CELL,  1'b0, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd1, R_ALIVE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b0, 11'd0, 1'b1, 2'd2, R_ALIVE, R_ALIVE},
        '{ROW_WORD, OP_FLUSH, 1'b0, 11'd0, 1'b1, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b1, 2'd1, R_DEAD, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b0, 11'd0, 1'b1, 2'd2, R_DEAD, R_DEAD_LAST},
        // A fully live 3x3 block: the center has eight neighbors, the edges
        // five and the corners three, so the neighbor count reaches eight.
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_CELL,  1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b0, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b1, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE},
        '{ROW_WORD, OP_FLUSH, 1'b0, 11'd0, 1'b0, 2'd0, R_NONE, R_NONE}
    };

    logic clk;
    logic rst_n;

    lgs_in_if  cell_ch ();
    lgs_out_if result_ch ();
    lgs_cfg_if size_ch ();

    life_generation_stencil DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_in    (cell_ch),
        .result_out (result_ch),
        .cfg        (size_ch)
    );

    // Generation predictor state: board side, the two line buffers, the 3x3
    // window and the raster position of the next word.
    int unsigned         board_side;
    logic                above_mem [MAX_SIDE];
    logic                two_above_mem [MAX_SIDE];
    logic [WINDOW_W-1:0] stencil_win;
    int unsigned         col_pos;
    int unsigned         row_pos;

    // Next-generation results still owed by the block, oldest first.
    result_t next_gen_q [$];

    int unsigned mismatch_count;
    int unsigned words_accepted;
    int unsigned results_checked;
    int unsigned size_writes;
    int unsigned smallest_write;
    int unsigned largest_write;
    bit          calm_in;
    bit          calm_out;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // B3/S23: three neighbors give birth or survival, two keep the old state,
    // any other count is death. Counts above three all behave the same.
    function automatic logic life_rule(input logic [WINDOW_W-1:0] w);
        int k;
        k = $countones(w & NEIGHBOR_MASK);
        if (k == 3)
        begin
            return 1'b1;
        end
        if (k == 2)
        begin
            return w[CENTER_BIT];
        end
        return 1'b0;
    endfunction

    function automatic void apply_board_size(input logic [BOARD_SIZE_W-1:0] v);
        int unsigned s;
        s = 32'(v);
        if (s < 1)
        begin
            s = 1;
        end
        if (s > MAX_SIDE)
        begin
            s = MAX_SIDE;
        end
        board_side = s;
        col_pos    = 0;
        row_pos    = 0;
    endfunction

    function automatic void reset_generation();
        board_side  = RESET_BOARD_SIZE;
        stencil_win = '0;
        col_pos     = 0;
        row_pos     = 0;
        for (int i = 0; i < MAX_SIDE; i++)
        begin
            above_mem[i]     = 1'b0;
            two_above_mem[i] = 1'b0;
        end
    endfunction

    // Advances the predictor by one accepted word and returns how many
    // next-generation results that word releases.
    function automatic int step_generation(input logic op, input logic alive,
                                           output result_t res_a, output result_t res_b);
        logic    cur;
        logic    top;
        logic    mid;
        int      cnt;
        result_t tail;
        res_a = R_NONE;
        res_b = R_NONE;
        // Position alone decides the role of a word: a flush word inside the
        // frame and a cell word in the flush row are both dead cells.
        cur = (op == OP_CELL && row_pos < board_side) ? alive : 1'b0;
        // Rows above the board are dead, whatever the buffers hold from an
        // earlier frame.
        top = (row_pos >= 2) ? two_above_mem[col_pos] : 1'b0;
        mid = (row_pos >= 1) ? above_mem[col_pos] : 1'b0;
        two_above_mem[col_pos] = above_mem[col_pos];
        above_mem[col_pos]     = cur;
        if (col_pos == 0)
        begin
            stencil_win = '0;
        end
        stencil_win = {stencil_win[5:0], cur, mid, top};
        cnt = 0;
        if (row_pos >= 1)
        begin
            // The cell one column back now has all its neighbors. It is never
            // the last column, so it never closes the frame.
            if (col_pos >= 1)
            begin
                res_a = '{life_rule(stencil_win), 1'b0};
                cnt   = 1;
            end
            // At the right edge the current column also completes, with a dead
            // column beyond the board.
            if (col_pos == board_side - 1)
            begin
                tail = '{life_rule({stencil_win[5:0], 3'b000}), row_pos == board_side};
                if (cnt == 0)
                begin
                    res_a = tail;
                end
                else
                begin
                    res_b = tail;
                end
                cnt++;
            end
        end
        col_pos++;
        if (col_pos >= board_side)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos > board_side)
            begin
                row_pos = 0;
            end
        end
        return cnt;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Sends one word after a random gap and books the results it owes. Rows
    // of the directed table may hand in the expected results directly; the
    // predictor is stepped either way so its state stays in line.
    task automatic send_word(input logic op, input logic alive,
                             input bit use_typed = 1'b0, input logic [1:0] typed_n = 2'd0,
                             input result_t typed_a = '0, input result_t typed_b = '0);
        int      gap;
        int      cnt;
        result_t res_a;
        result_t res_b;
        gap = draw_wait(calm_in);
        @(negedge clk);
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.op         <= op;
        cell_ch.cell_alive <= alive;
        do
        begin
            @(posedge clk);
        end
        while (!cell_ch.ready);
        cnt = step_generation(op, alive, res_a, res_b);
        if (use_typed)
        begin
            cnt   = int'(typed_n);
            res_a = typed_a;
            res_b = typed_b;
        end
        if (cnt >= 1)
        begin
            next_gen_q.push_back(res_a);
        end
        if (cnt >= 2)
        begin
            next_gen_q.push_back(res_b);
        end
        words_accepted++;
    endtask

    // Drops valid and holds off until every owed result has been taken.
    task automatic quiesce(input int settle);
        @(negedge clk);
        cell_ch.valid <= 1'b0;
        while (next_gen_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // The size register is only written with the stencil idle.
    task automatic change_board_size(input int unsigned value);
        quiesce(SETTLE_CYCLES);
        @(negedge clk);
        size_ch.valid      <= 1'b1;
        size_ch.board_size <= BOARD_SIZE_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!size_ch.ready);
        apply_board_size(BOARD_SIZE_W'(value));
        size_writes++;
        if (value < smallest_write)
        begin
            smallest_write = value;
        end
        if (value > largest_write)
        begin
            largest_write = value;
        end
        @(negedge clk);
        size_ch.valid <= 1'b0;
    endtask

    // Streams one frame of an n x n board plus its flush row, or its first
    // cutoff words. Most words are well formed; a few are swapped so that
    // flush words land in the frame and cell words land in the flush row.
    task automatic send_frame(input int unsigned n, input int unsigned cutoff,
                              input bit pause_once);
        int unsigned total;
        int unsigned density;
        int unsigned pause_at;
        logic        op;
        logic        alive;
        total = n * n + n;
        if (cutoff < total)
        begin
            total = cutoff;
        end
        density  = $urandom_range(0, 4) * 25;
        calm_in  = ($urandom_range(0, 3) == 0);
        pause_at = $urandom_range(0, total - 1);
        for (int unsigned k = 0; k < total; k++)
        begin
            if (pause_once && k == pause_at)
            begin
                quiesce(0);
            end
            if (k < n * n)
            begin
                op    = ($urandom_range(0, 23) == 0) ? OP_FLUSH : OP_CELL;
                alive = ($urandom_range(0, 99) < density);
            end
            else
            begin
                op    = ($urandom_range(0, 3) == 0) ? OP_CELL : OP_FLUSH;
                alive = 1'($urandom_range(0, 1));
            end
            send_word(op, alive);
        end
    endtask

    // Result side: after each accepted word ready may drop for a random
    // number of cycles. Now and then a calm stretch keeps ready high.
    initial
    begin
        int stall;
        calm_out        = 1'b0;
        result_ch.ready = 1'b1;
        forever
        begin
            do
            begin
                @(posedge clk);
            end
            while (!(result_ch.valid && result_ch.ready));
            if ($urandom_range(0, 63) == 0)
            begin
                calm_out = !calm_out;
            end
            stall = draw_wait(calm_out);
            if (stall > 0)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted result word is checked against the oldest owed result.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.next_alive, result_ch.frame_last};
            if (next_gen_q.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing owed: next_alive=%0b frame_last=%0b",
                                          got.next_alive, got.frame_last));
            end
            else
            begin
                want = next_gen_q.pop_front();
                if (got.next_alive !== want.next_alive)
                begin
                    report_mismatch($sformatf("result %0d next_alive got %0b want %0b",
                                              results_checked, got.next_alive,
                                              want.next_alive));
                end
                if (got.frame_last !== want.frame_last)
                begin
                    report_mismatch($sformatf("result %0d frame_last got %0b want %0b",
                                              results_checked, got.frame_last,
                                              want.frame_last));
                end
                results_checked++;
            end
        end
    end

    // Watchdog: the run is stuck if no word moves on any channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cell_ch.valid && cell_ch.ready) || (result_ch.valid && result_ch.ready)
                || (size_ch.valid && size_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no word moved for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, next_gen_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        stim_row_t   trow;
        int unsigned bulk_start;
        int unsigned pick;
        int unsigned size_val;
        int unsigned frames;
        int unsigned cutoff;

        // Every block input is known from time zero.
        rst_n              = 1'b0;
        cell_ch.valid      = 1'b0;
        cell_ch.op         = OP_CELL;
        cell_ch.cell_alive = 1'b0;
        size_ch.valid      = 1'b0;
        size_ch.board_size = '0;
        calm_in            = 1'b0;
        mismatch_count     = 0;
        words_accepted     = 0;
        results_checked    = 0;
        size_writes        = 0;
        smallest_write     = 32'hffff_ffff;
        largest_write      = 0;
        reset_generation();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset board size: two rows at the default side show it through the
        // position of the double result at the right edge. The sender also
        // stops once here until every owed result has come back.
        send_frame(RESET_BOARD_SIZE, 2 * RESET_BOARD_SIZE + 17, 1'b1);

        // Directed table: size clamping, a blinker with misplaced words, and
        // a full block that saturates the neighbor count.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            trow = directed_tbl[i];
            if (trow.kind == ROW_SIZE)
            begin
                change_board_size(32'(trow.size));
            end
            else
            begin
                send_word(trow.op, trow.alive, trow.typed, trow.typed_n,
                          trow.res_a, trow.res_b);
            end
        end

        // Largest boards: an exact write of the maximum side, then an
        // all-ones write that must clamp to it. One full row at the clamped
        // side and the first cells of the next row show the row length; the
        // next write abandons the frame.
        change_board_size(MAX_SIDE);
        send_frame(MAX_SIDE, 3, 1'b0);
        change_board_size((1 << BOARD_SIZE_W) - 1);
        send_frame(board_side, board_side + 3, 1'b0);

        // Bulk random part, mostly small boards with whole frames. Some
        // frames are cut short and the next size write restarts the raster.
        bulk_start = words_accepted;
        while (words_accepted - bulk_start < BULK_WORDS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                size_val = 0;
            end
            else if (pick < 14)
            begin
                size_val = $urandom_range(1, 6);
            end
            else if (pick < 18)
            begin
                size_val = $urandom_range(7, 16);
            end
            else
            begin
                size_val = $urandom_range(17, 24);
            end
            change_board_size(size_val);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
            begin
                cutoff = FULL_FRAME;
                if (f == frames - 1 && $urandom_range(0, 5) == 0)
                begin
                    cutoff = $urandom_range(1, board_side * board_side);
                end
                send_frame(board_side, cutoff, $urandom_range(0, 2) == 0);
            end
        end

        // Drain, then give the pipeline time to show any stray result.
        quiesce(SETTLE_CYCLES);

        $display("run covered %0d words, %0d results checked, %0d board size writes",
                 words_accepted, results_checked, size_writes);
        $display("board sizes written from %0d to %0d, %0d mismatches",
                 smallest_write, largest_write, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* life_generation_stencil.f */
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_line_mem.sv
design/lgs_result_fifo.sv
design/life_generation_stencil.sv
design/lgs_checker.sv
verif/tb_life_generation_stencil.sv
